@@ rtl/core/heading_pi_rudder_controller_unit_defines.svh @@
// Assertion macros for the heading controller RTL.
// Define ASSERT_OFF to compile every assertion out.
`ifndef HEADING_PI_RUDDER_CONTROLLER_UNIT_DEFINES_SVH
`define HEADING_PI_RUDDER_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked assertion that is switched off while reset is high.
`define HPRC_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HPRC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HPRC_ASSERT(name, clk, rst, prop, msg)
`define HPRC_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

@@ rtl/core/hprc_pkg.sv @@
package hprc_pkg;

  // Fraction bits of the integral accumulator.
  localparam int FRAC_BITS = 16;

  // Field widths fixed by the interface.
  localparam int HEAD_W    = 9;
  localparam int ERR_W     = 9;
  localparam int RUD_W     = 8;
  localparam int PULSE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int ILIM_W    = 13;
  localparam int RLIM_W    = 7;
  localparam int STEP_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Datapath widths derived from the fraction bits.
  localparam int MAG_W    = ILIM_W + FRAC_BITS;       // clipped integral magnitude
  localparam int ACC_W    = MAG_W + 1;                // signed integral
  localparam int SUM_W    = ACC_W + 1;                // integral plus error, before clip
  localparam int DPROD_W  = MAG_W + GAIN_W;           // decay product
  localparam int PPROD_W  = GAIN_W + 1 + ERR_W;       // proportional product
  localparam int IPROD_W  = GAIN_W + 1 + ACC_W;       // integral term product
  localparam int CSUM_W   = IPROD_W + 1;              // command sum
  localparam int CSHIFT   = GAIN_W + FRAC_BITS;       // command rounding shift
  localparam int RMAG_W   = CSUM_W + 1 - CSHIFT;      // rounded command magnitude
  localparam int PSUM_W   = 20;                       // pulse sum before saturation

  // Rounding offsets: half of one unit after the decay and command shifts.
  localparam logic [DPROD_W-1:0] DECAY_HALF = {{(DPROD_W-1){1'b0}}, 1'b1} << (GAIN_W - 1);
  localparam logic [CSUM_W:0]    CMAG_HALF  = {{CSUM_W{1'b0}}, 1'b1} << (CSHIFT - 1);

  localparam logic signed [ERR_W:0] HALF_TURN = 10'sd180;
  localparam logic signed [ERR_W:0] FULL_TURN = 10'sd360;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RUDDER_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CENTER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_STEP   = 3'd6;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  decay_factor;
    logic [ILIM_W-1:0]  integ_limit;
    logic [RLIM_W-1:0]  rudder_limit;
    logic [PULSE_W-1:0] pulse_center;
    logic [STEP_W-1:0]  pulse_step;
  } cfg_t;

  // One strobe per datapath step.
  typedef struct packed {
    logic load;
    logic clip;
    logic decay;
    logic integ;
    logic sum;
    logic round;
    logic pulse;
  } cmd_t;

endpackage

@@ rtl/core/hprc_cfg_regs.sv @@
module hprc_cfg_regs
  import hprc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain    <= 16'd6554;
      cfg.integ_gain   <= 16'd655;
      cfg.decay_factor <= 16'd58982;
      cfg.integ_limit  <= 13'd4000;
      cfg.rudder_limit <= 7'd5;
      cfg.pulse_center <= 16'd1500;
      cfg.pulse_step   <= 10'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROP_GAIN:    cfg.prop_gain    <= cfg_data;
        CFG_INTEG_GAIN:   cfg.integ_gain   <= cfg_data;
        CFG_DECAY_FACTOR: cfg.decay_factor <= cfg_data;
        CFG_INTEG_LIMIT:  cfg.integ_limit  <= cfg_data[ILIM_W-1:0];
        CFG_RUDDER_LIMIT: cfg.rudder_limit <= cfg_data[RLIM_W-1:0];
        CFG_PULSE_CENTER: cfg.pulse_center <= cfg_data;
        CFG_PULSE_STEP:   cfg.pulse_step   <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/hprc_ctrl.sv @@
`include "heading_pi_rudder_controller_unit_defines.svh"

module hprc_ctrl
  import hprc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLIP  = 7'b0000010,
    ST_DECAY = 7'b0000100,
    ST_INTEG = 7'b0001000,
    ST_SUM   = 7'b0010000,
    ST_ROUND = 7'b0100000,
    ST_PULSE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CLIP;
        end
      end
      ST_CLIP: begin
        cmd.clip   = 1'b1;
        state_next = ST_DECAY;
      end
      ST_DECAY: begin
        cmd.decay  = 1'b1;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = ST_PULSE;
      end
      ST_PULSE: begin
        // Wait until the output register is free before writing it.
        if (!out_valid || !out_stall) begin
          cmd.pulse      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `HPRC_ASSERT(a_accept_starts, clk, rst, (in_valid && !in_stall) |=> (state == ST_CLIP), "accepted item did not start the sequence")
  `HPRC_ASSERT(a_no_overwrite, clk, rst, cmd.pulse |-> (!out_valid || !out_stall), "result written over a waiting result")
  `HPRC_ASSERT(a_valid_source, clk, rst, $rose(out_valid) |-> $past(state == ST_PULSE), "result shown without a pulse step")
  `HPRC_ASSERT_ALWAYS(a_busy_stalls, clk, (state != ST_IDLE) |-> in_stall, "input taken while busy")

endmodule

@@ rtl/core/hprc_datapath.sv @@
module hprc_datapath
  import hprc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  cfg_t                      cfg,
  input  logic [HEAD_W-1:0]         target_heading,
  input  logic [HEAD_W-1:0]         measured_heading,
  output logic signed [ERR_W-1:0]   heading_error,
  output logic signed [RUD_W-1:0]   rudder_cmd,
  output logic [PULSE_W-1:0]        servo_pulse
);

  // Stored integral state.
  logic signed [ACC_W-1:0]   integral_acc;

  logic signed [ERR_W-1:0]   err;
  logic [MAG_W-1:0]          clip_mag;
  logic                      clip_neg;
  logic signed [PPROD_W-1:0] prop_prod;
  logic signed [IPROD_W-1:0] integ_prod;
  logic signed [CSUM_W-1:0]  csum;
  logic signed [RUD_W-1:0]   rud;

  logic signed [ERR_W:0]     err_raw;
  logic signed [ERR_W:0]     err_wrap;
  logic signed [SUM_W-1:0]   acc_sum;
  logic [SUM_W-1:0]          acc_mag;
  logic [MAG_W-1:0]          lim;
  logic [DPROD_W-1:0]        dprod;
  logic [DPROD_W-1:0]        dround;
  logic [MAG_W-1:0]          dmag;
  logic [CSUM_W-1:0]         cmag;
  logic [CSUM_W:0]           cround;
  logic [RMAG_W-1:0]         rmag;
  logic [RLIM_W-1:0]         rclamp;
  logic signed [PSUM_W-1:0]  pprod;
  logic signed [PSUM_W-1:0]  psum;

  // Heading error with one wrap correction.
  always_comb begin
    err_raw = $signed({1'b0, target_heading}) - $signed({1'b0, measured_heading});
    if (err_raw < -HALF_TURN) begin
      err_wrap = err_raw + FULL_TURN;
    end else if (err_raw > HALF_TURN) begin
      err_wrap = err_raw - FULL_TURN;
    end else begin
      err_wrap = err_raw;
    end
  end

  // Integrate and clip by magnitude.
  always_comb begin
    acc_sum = SUM_W'(integral_acc) + (SUM_W'(err) <<< FRAC_BITS);
    acc_mag = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);
    lim     = MAG_W'(cfg.integ_limit) << FRAC_BITS;
  end

  // Decay, rounded half away from zero on the magnitude.
  always_comb begin
    dprod  = clip_mag * cfg.decay_factor;
    dround = dprod + DECAY_HALF;
    dmag   = dround[DPROD_W-1:GAIN_W];
  end

  // Command rounding and clamp.
  always_comb begin
    cmag   = csum[CSUM_W-1] ? CSUM_W'(-csum) : CSUM_W'(csum);
    cround = {1'b0, cmag} + CMAG_HALF;
    rmag   = cround[CSUM_W:CSHIFT];
    if (rmag > RMAG_W'(cfg.rudder_limit)) begin
      rclamp = cfg.rudder_limit;
    end else begin
      rclamp = rmag[RLIM_W-1:0];
    end
  end

  always_comb begin
    pprod = rud * $signed({1'b0, cfg.pulse_step});
    psum  = pprod + $signed({{(PSUM_W-PULSE_W){1'b0}}, cfg.pulse_center});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
    end else if (cmd.decay) begin
      integral_acc <= clip_neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err <= err_wrap[ERR_W-1:0];
    end
    if (cmd.clip) begin
      clip_neg  <= acc_sum[SUM_W-1];
      clip_mag  <= (acc_mag > {2'b00, lim}) ? lim : acc_mag[MAG_W-1:0];
      prop_prod <= $signed({1'b0, cfg.prop_gain}) * err;
    end
    if (cmd.integ) begin
      integ_prod <= $signed({1'b0, cfg.integ_gain}) * integral_acc;
    end
    if (cmd.sum) begin
      csum <= CSUM_W'(integ_prod) + (CSUM_W'(prop_prod) <<< FRAC_BITS);
    end
    if (cmd.round) begin
      rud <= csum[CSUM_W-1] ? -$signed({1'b0, rclamp}) : $signed({1'b0, rclamp});
    end
    if (cmd.pulse) begin
      heading_error <= err;
      rudder_cmd    <= rud;
      if (psum[PSUM_W-1]) begin
        servo_pulse <= '0;
      end else if (psum > $signed(PSUM_W'(17'h0FFFF))) begin
        servo_pulse <= '1;
      end else begin
        servo_pulse <= psum[PULSE_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/heading_pi_rudder_controller_unit.sv @@
// An accepted input item walks through the clip, decay, integral, sum, round and pulse steps in order.
// A new item is taken only in the idle state, after the six sequencer steps of the last item are done.
// A waiting result does not hold off the next input item; that item's last step holds while
// the prior result stalls.
// Reset (synchronous, active high) clears the integral, loads default register values,
// and empties the output register.

// The controller walks one item through seven dependent steps: capture and wrap the heading
// error, add it to the integral and clip, apply the decay multiply, form the integral term,
// add the proportional term, round and clamp the rudder command, and finally form the
// saturated servo pulse. The datapath registers each step, so no path carries more than
// one multiplier. Configuration writes are taken in any cycle and are expected only
// while no item is in flight.
module heading_pi_rudder_controller_unit
  import hprc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [HEAD_W-1:0]        target_heading,
  input  logic [HEAD_W-1:0]        measured_heading,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ERR_W-1:0]  heading_error,
  output logic signed [RUD_W-1:0]  rudder_cmd,
  output logic [PULSE_W-1:0]       servo_pulse,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_data
);

  cfg_t cfg;
  cmd_t cmd;

  // Register file for gains, limits and servo scaling.
  hprc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: owns the handshakes; one step strobe per cycle, except while idle or stalled.
  hprc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic and the kept integral; the output register lives here.
  hprc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .target_heading   (target_heading),
    .measured_heading (measured_heading),
    .heading_error    (heading_error),
    .rudder_cmd       (rudder_cmd),
    .servo_pulse      (servo_pulse)
  );

endmodule
